// ===== hdl/b64e_pkg.sv =====
`timescale 1ns / 1ps

package b64e_pkg;

   localparam logic [6:0] PAD_CHAR = 7'd61;
   localparam logic [6:0] CR_CHAR  = 7'd13;
   localparam logic [6:0] LF_CHAR  = 7'd10;
   localparam logic [5:0] QUADS_PER_LINE_RESET = 6'd19;
   localparam int         RUN_MAX = 4;

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_of_run;
      logic       message_done;
   } rsp_type;

   typedef struct packed {
      logic [RUN_MAX-1:0][6:0] chars;
      logic [1:0]              last_idx;
      logic                    eom;
   } run_type;

   function automatic logic [6:0] b64_symbol(input logic [5:0] v);
      logic [6:0] code;
      if (v < 6'd26) begin
         code = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
         code = 7'd71 + {1'b0, v};
      end else if (v < 6'd62) begin
         code = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
         code = 7'd43;
      end else begin
         code = 7'd47;
      end
      return code;
   endfunction

endpackage

// ===== hdl/b64e_encode.sv =====
`timescale 1ns / 1ps

module b64e_encode (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64e_pkg::req_type req_data,
   input  logic              csr_write,
   input  logic [5:0]        csr_data,
   input  logic              load_ok,
   output logic              run_valid,
   output b64e_pkg::run_type run
);
   import b64e_pkg::*;

   req_type    item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic [5:0] lqc_ff, lqc_in;
   logic [5:0] qpl_ff, qpl_in;
   logic       advance;
   logic       take;
   logic [6:0] cnt;
   logic [7:0] b;

   assign advance   = item_valid_ff & load_ok;
   assign req_stall = item_valid_ff & ~load_ok;
   assign take      = req_valid & ~req_stall;
   assign run_valid = item_valid_ff;
   assign b         = item_ff.data_byte;

   always_comb begin
      item_in       = take ? req_data : item_ff;
      item_valid_in = take | (item_valid_ff & ~advance);
      qpl_in        = csr_write ? csr_data : qpl_ff;
   end

   always_comb begin
      run.chars    = '0;
      run.last_idx = 2'd0;
      run.eom      = item_ff.end_of_message;
      phase_in     = phase_ff;
      carry_in     = carry_ff;
      lqc_in       = lqc_ff;
      cnt          = {1'b0, lqc_ff} + 7'd1;
      case (phase_ff)
         PHASE_1: begin
            run.chars[0] = b64_symbol({carry_ff[1:0], b[7:4]});
            carry_in     = b[3:0];
            phase_in     = PHASE_2;
            if (item_ff.end_of_message) begin
               run.chars[1] = b64_symbol({b[3:0], 2'b00});
               run.chars[2] = PAD_CHAR;
               run.last_idx = 2'd2;
            end
         end
         PHASE_2: begin
            run.chars[0] = b64_symbol({carry_ff, b[7:6]});
            run.chars[1] = b64_symbol(b[5:0]);
            run.last_idx = 2'd1;
            carry_in     = 4'd0;
            phase_in     = PHASE_0;
            if (qpl_ff != 6'd0) begin
               if (cnt >= {1'b0, qpl_ff}) begin
                  run.chars[2] = CR_CHAR;
                  run.chars[3] = LF_CHAR;
                  run.last_idx = 2'd3;
                  lqc_in       = 6'd0;
               end else begin
                  lqc_in = cnt[5:0];
               end
            end else begin
               lqc_in = 6'd0;
            end
         end
         default: begin
            run.chars[0] = b64_symbol(b[7:2]);
            carry_in     = {2'b00, b[1:0]};
            phase_in     = PHASE_1;
            if (item_ff.end_of_message) begin
               run.chars[1] = b64_symbol({b[1:0], 4'b0000});
               run.chars[2] = PAD_CHAR;
               run.chars[3] = PAD_CHAR;
               run.last_idx = 2'd3;
            end
         end
      endcase
      if (item_ff.end_of_message) begin
         phase_in = PHASE_0;
         carry_in = 4'd0;
         lqc_in   = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PHASE_0;
         carry_ff      <= 4'd0;
         lqc_ff        <= 6'd0;
         qpl_ff        <= QUADS_PER_LINE_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         qpl_ff        <= qpl_in;
         if (advance) begin
            phase_ff <= phase_in;
            carry_ff <= carry_in;
            lqc_ff   <= lqc_in;
         end
      end
   end

endmodule

// ===== hdl/b64e_serial.sv =====
`timescale 1ns / 1ps

module b64e_serial (
   input  logic              clock,
   input  logic              reset,
   input  logic              run_valid,
   input  b64e_pkg::run_type run,
   output logic              load_ok,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64e_pkg::rsp_type rsp_data
);
   import b64e_pkg::*;

   run_type    run_ff, run_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_last;
   logic       take;

   assign at_last   = idx_ff == run_ff.last_idx;
   assign take      = valid_ff & ~rsp_stall;
   assign load_ok   = ~valid_ff | (take & at_last);
   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_data.out_char     = run_ff.chars[idx_ff];
      rsp_data.last_of_run  = at_last;
      rsp_data.message_done = at_last & run_ff.eom;
   end

   always_comb begin
      run_in   = run_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load_ok) begin
         run_in   = run;
         idx_in   = 2'd0;
         valid_in = run_valid;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== hdl/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake       Payload
// req      in         valid / stall   data_byte, end_of_message
// rsp      out        valid / stall   out_char, last_of_run, message_done
// csr      in         valid / ready   quads_per_line (6 bits)
//
// A byte is taken into an input register, encoded in the next cycle into a
// run of one to four characters, and the run is sent out one character a cycle
// while rsp is not stalled. Sustained rate is set by the output port.
// A new byte is accepted while the previous run drains its last character.
// Reset is synchronous; quads_per_line returns to 19 and the encoder to phase 0.
// A stall on rsp holds the current character and backs up into req_stall.

module base64_stream_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64e_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64e_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [5:0]        csr_data
);
   import b64e_pkg::*;

   run_type run;
   logic    run_valid;
   logic    load_ok;

   assign csr_ready = 1'b1;

   b64e_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .load_ok   (load_ok),
      .run_valid (run_valid),
      .run       (run)
   );

   b64e_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .run_valid (run_valid),
      .run       (run),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/base64_stream_encoder_tb.sv =====
`timescale 1ns / 1ps

module base64_stream_encoder_tb;
   import b64e_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam logic [511:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [5:0] csr_data = '0;

   req_type    pending_bytes [$];
   rsp_type    expected_chars [$];

   phase_type  enc_phase = PHASE_0;
   logic [3:0] enc_carry = '0;
   logic [5:0] enc_quads = '0;
   logic [5:0] line_limit = QUADS_PER_LINE_RESET;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   base64_stream_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [6:0] symbol_of(input logic [5:0] v);
      int pos;
      pos = 8 * (63 - int'(v));
      return ALPHABET[pos +: 7];
   endfunction

   task automatic predict_chars(input req_type item);
      logic [6:0] run_chars [$];
      logic [7:0] b;
      logic [6:0] cnt;
      rsp_type    r;
      b = item.data_byte;
      case (enc_phase)
         PHASE_1: begin
            run_chars.push_back(symbol_of({enc_carry[1:0], b[7:4]}));
            enc_carry = b[3:0];
            enc_phase = PHASE_2;
            if (item.end_of_message) begin
               run_chars.push_back(symbol_of({b[3:0], 2'b00}));
               run_chars.push_back(PAD_CHAR);
            end
         end
         PHASE_2: begin
            run_chars.push_back(symbol_of({enc_carry, b[7:6]}));
            run_chars.push_back(symbol_of(b[5:0]));
            enc_carry = '0;
            enc_phase = PHASE_0;
            if (line_limit != 0) begin
               cnt = {1'b0, enc_quads} + 7'd1;
               if (cnt >= {1'b0, line_limit}) begin
                  run_chars.push_back(CR_CHAR);
                  run_chars.push_back(LF_CHAR);
                  cnt = '0;
               end
               enc_quads = cnt[5:0];
            end else begin
               enc_quads = '0;
            end
         end
         default: begin
            run_chars.push_back(symbol_of(b[7:2]));
            enc_carry = {2'b00, b[1:0]};
            enc_phase = PHASE_1;
            if (item.end_of_message) begin
               run_chars.push_back(symbol_of({b[1:0], 4'b0000}));
               run_chars.push_back(PAD_CHAR);
               run_chars.push_back(PAD_CHAR);
            end
         end
      endcase
      foreach (run_chars[k]) begin
         r.out_char = run_chars[k];
         r.last_of_run = (k == run_chars.size() - 1);
         r.message_done = item.end_of_message && (k == run_chars.size() - 1);
         expected_chars.push_back(r);
      end
      if (item.end_of_message) begin
         enc_phase = PHASE_0;
         enc_carry = '0;
         enc_quads = '0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_chars(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t unexpected item: char %0d last %0b done %0b", $time,
                        rsp_data.out_char, rsp_data.last_of_run, rsp_data.message_done);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                           $time, want.out_char, want.last_of_run, want.message_done,
                           rsp_data.out_char, rsp_data.last_of_run, rsp_data.message_done);
                  mismatches++;
               end
            end
         end
         if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic eom);
      req_type item;
      item.data_byte = b;
      item.end_of_message = eom;
      pending_bytes.push_back(item);
   endtask

   task automatic queue_message(input int len, input bit close);
      for (int i = 0; i < len; i++) begin
         queue_byte(8'($urandom), close && (i == len - 1));
      end
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0 || req_valid || expected_chars.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_quads(input logic [5:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      line_limit = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int n;
      int len;
      logic [5:0] v;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 37;
      recv_idle_pct = 77;
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFB, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h80, 1'b1);
      queue_byte(8'hFC, 1'b0);
      queue_byte(8'h03, 1'b0);
      queue_byte(8'hF0, 1'b1);

      // final byte completes a full line
      drain();
      write_quads(6'd1);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'h56, 1'b0);
      queue_byte(8'h78, 1'b0);
      queue_byte(8'h9A, 1'b0);
      queue_byte(8'hBC, 1'b1);

      // line breaks off
      drain();
      write_quads(6'd0);
      queue_message(3, 1'b1);

      // lower the limit mid-line
      drain();
      write_quads(6'd63);
      queue_message(6, 1'b0);
      drain();
      write_quads(6'd1);
      queue_message(3, 1'b1);

      for (int p = 0; p < 9; p++) begin
         drain();
         if (p < 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 77;
         end else if (p < 6) begin
            send_idle_pct = 77;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (p)
            0: v = 6'd1;
            1: v = 6'd63;
            2: v = 6'($urandom_range(2, 8));
            3: v = 6'd0;
            4: v = 6'($urandom_range(0, 63));
            5: v = 6'd2;
            6: v = 6'd19;
            7: v = 6'($urandom_range(1, 5));
            default: v = 6'd63;
         endcase
         write_quads(v);
         n = 0;
         while (n < 14) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
            queue_message(len, $urandom_range(7) != 0);
            n += len;
         end
         if (p == 6) begin
            hold_requests++;
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
